[hdl/p2c_pkg.sv]
// Shared types, constants and helpers for the planar-to-chunky palette lookup.
// No dependencies; imported by p2c_palette and planar_to_chunky_palette_lookup.

package p2c_pkg;

   localparam int PALETTE_ENTRIES = 256;
   localparam int PAL_AW          = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
   localparam int MAX_PLANES      = 8;
   localparam int PIXELS_PER_ITEM = 8;
   localparam int FIFO_DEPTH      = 4;
   localparam int FIFO_AW         = 2;

   localparam logic [7:0] HALF_BASE  = 8'd224;
   localparam logic [7:0] HALF_LIMIT = 8'd32;
   localparam logic [7:0] ALPHA      = 8'hff;

   localparam logic [1:0] KIND_WRITE  = 2'd0;
   localparam logic [1:0] KIND_PLANAR = 2'd1;
   localparam logic [1:0] KIND_CHUNKY = 2'd2;

   localparam logic CSR_PLANE_COUNT  = 1'b0;
   localparam logic CSR_PIXEL_FORMAT = 1'b1;

   typedef struct packed {
      logic        en;
      logic [7:0]  addr;
      logic [15:0] c565;
      logic [23:0] c888;
   } pal_wr_type;

   typedef struct packed {
      logic       en;
      logic [7:0] addr;
   } pal_rd_type;

   // floor(v/3) for v < 512 (9-bit input) via reciprocal 683/2048
   function automatic logic [7:0] third(input logic [8:0] v);
      logic [18:0] prod;
      prod = 19'(v) * 19'd683;
      return prod[18:11];
   endfunction

endpackage

[hdl/p2c_palette.sv]
// Palette store: one synchronous RAM holding RGB565 and RGB888 per entry.
// Per-entry valid bits make unwritten entries read as zero. Uses p2c_pkg.

module p2c_palette
   import p2c_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  pal_wr_type  wr,
   input  pal_rd_type  rd,
   output logic [15:0] rd_c565,
   output logic [23:0] rd_c888
);

   logic [39:0]                mem [PALETTE_ENTRIES];
   logic [PALETTE_ENTRIES-1:0] valid_ff;
   logic [39:0]                rd_data_ff;
   logic                       hit_ff;
   logic                       wr_in_range;
   logic                       rd_in_range;

   assign wr_in_range = {1'b0, wr.addr} < 9'(PALETTE_ENTRIES);
   assign rd_in_range = {1'b0, rd.addr} < 9'(PALETTE_ENTRIES);

   always_ff @(posedge clock) begin
      if (wr.en && wr_in_range) begin
         mem[wr.addr[PAL_AW-1:0]] <= {wr.c565, wr.c888};
      end
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr[PAL_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hit_ff   <= 1'b0;
      end else begin
         if (wr.en && wr_in_range) begin
            valid_ff[wr.addr[PAL_AW-1:0]] <= 1'b1;
         end
         if (rd.en) begin
            hit_ff <= rd_in_range && valid_ff[rd.addr[PAL_AW-1:0]];
         end
      end
   end

   assign rd_c565 = hit_ff ? rd_data_ff[39:24] : 16'd0;
   assign rd_c888 = hit_ff ? rd_data_ff[23:0]  : 24'd0;

endmodule

[hdl/planar_to_chunky_palette_lookup.sv]
// Top level: item sequencer, palette access and output queue.
// Depends on p2c_pkg and p2c_palette.
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  tdata: plane_bytes..make_half, tuser: kind
//   rsp      out  rsp_tvalid/rsp_tready  tdata: pixel, tlast: last
//   csr      in   csr_we                 csr_index, csr_wdata
//
// Planar item: one palette read per pixel, eight pixels. Chunky item: one palette read.
// Palette write: one RAM write, plus a second for the dimmed copy when it is stored (one RAM write port).
// Read data returns in the cycle after issue into a 4-entry output queue; reads
// pause only when that queue plus the read in flight is full.
// Synchronous reset: palette reads as zero, plane_count 8, RGB565 output.

module planar_to_chunky_palette_lookup
   import p2c_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [103:0] req_tdata,  // plane_bytes, color_index, red, green, blue, make_half
   input  logic [1:0]   req_tuser,  // kind
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,  // pixel
   output logic         rsp_tlast,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [3:0]   csr_wdata
);

   logic [3:0]  plane_count_ff;
   logic        pixel_format_ff;

   logic        busy_ff, busy_in;
   logic [1:0]  kind_ff;
   logic [63:0] planes_ff;
   logic [7:0]  idx_ff, red_ff, green_ff, blue_ff;
   logic        half_ff;
   logic [2:0]  cnt_ff, cnt_in;

   logic        inflight_ff;
   logic        last_ff;

   logic [32:0]        fifo_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_AW:0]   occ_ff, occ_in;

   logic        accept, is_read, room, go, op_last, push, pop, half_ok;
   logic [3:0]  np;
   logic [7:0]  planar_idx;
   logic [7:0]  dim_r5, dim_g6, dim_b5;
   logic [7:0]  dim_r8, dim_g8, dim_b8;
   logic [31:0] pixel;
   pal_wr_type  pal_wr;
   pal_rd_type  pal_rd;
   logic [15:0] rd_c565;
   logic [23:0] rd_c888;

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_count_ff  <= 4'd8;
         pixel_format_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PLANE_COUNT:  plane_count_ff  <= csr_wdata;
            CSR_PIXEL_FORMAT: pixel_format_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign half_ok = half_ff && (idx_ff < HALF_LIMIT);
   assign is_read = (kind_ff == KIND_PLANAR) || (kind_ff == KIND_CHUNKY);
   assign room    = ({1'b0, occ_ff} + {{(FIFO_AW+1){1'b0}}, inflight_ff})
                    <= (FIFO_AW+2)'(FIFO_DEPTH - 1);
   assign go      = busy_ff && (!is_read || room);

   always_comb begin
      case (kind_ff)
         KIND_WRITE:  op_last = (cnt_ff == 3'd1) || !half_ok;
         KIND_PLANAR: op_last = (cnt_ff == 3'(PIXELS_PER_ITEM - 1));
         default:     op_last = 1'b1;
      endcase
   end

   assign req_tready = !busy_ff || (go && op_last);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (accept) begin
         busy_in = 1'b1;
         cnt_in  = 3'd0;
      end else if (go) begin
         if (op_last) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff   <= req_tuser;
         planes_ff <= req_tdata[63:0];
         idx_ff    <= req_tdata[71:64];
         red_ff    <= req_tdata[79:72];
         green_ff  <= req_tdata[87:80];
         blue_ff   <= req_tdata[95:88];
         half_ff   <= req_tdata[96];
      end
   end

   // planar index: bit k from plane k at pixel column 7-cnt
   assign np = (plane_count_ff > 4'(MAX_PLANES)) ? 4'(MAX_PLANES) : plane_count_ff;

   always_comb begin
      planar_idx = 8'd0;
      for (int k = 0; k < MAX_PLANES; k++) begin
         if (4'(k) < np) begin
            planar_idx[k] = planes_ff[8*k + 7 - int'(cnt_ff)];
         end
      end
   end

   assign dim_r5 = third({3'd0, red_ff[7:3], 1'b0});
   assign dim_g6 = third({2'd0, green_ff[7:2], 1'b0});
   assign dim_b5 = third({3'd0, blue_ff[7:3], 1'b0});
   assign dim_r8 = third({red_ff, 1'b0});
   assign dim_g8 = third({green_ff, 1'b0});
   assign dim_b8 = third({blue_ff, 1'b0});

   always_comb begin
      pal_wr.en = go && (kind_ff == KIND_WRITE);
      if (cnt_ff == 3'd0) begin
         pal_wr.addr = idx_ff;
         pal_wr.c565 = {red_ff[7:3], green_ff[7:2], blue_ff[7:3]};
         pal_wr.c888 = {red_ff, green_ff, blue_ff};
      end else begin
         pal_wr.addr = HALF_BASE + idx_ff;
         pal_wr.c565 = {dim_r5[4:0], dim_g6[5:0], dim_b5[4:0]};
         pal_wr.c888 = {dim_r8, dim_g8, dim_b8};
      end
      pal_rd.en   = go && is_read;
      pal_rd.addr = (kind_ff == KIND_PLANAR) ? planar_idx : idx_ff;
   end

   p2c_palette u_palette (
      .clock   (clock),
      .reset   (reset),
      .wr      (pal_wr),
      .rd      (pal_rd),
      .rd_c565 (rd_c565),
      .rd_c888 (rd_c888)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= 1'b0;
      end else begin
         inflight_ff <= pal_rd.en;
      end
   end

   always_ff @(posedge clock) begin
      if (pal_rd.en) begin
         last_ff <= op_last;
      end
   end

   assign pixel = pixel_format_ff ? {ALPHA, rd_c888} : {16'd0, rd_c565};

   // output queue
   assign push = inflight_ff;
   assign pop  = rsp_tvalid && rsp_tready;

   always_comb begin
      occ_in = occ_ff;
      if (push && !pop) begin
         occ_in = occ_ff + (FIFO_AW+1)'(1);
      end else if (pop && !push) begin
         occ_in = occ_ff - (FIFO_AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         occ_ff    <= '0;
      end else begin
         occ_ff <= occ_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= {last_ff, pixel};
      end
   end

   assign rsp_tvalid = (occ_ff != '0);
   assign rsp_tdata  = fifo_ff[rd_ptr_ff][31:0];
   assign rsp_tlast  = fifo_ff[rd_ptr_ff][32];

`ifndef ASSERT_OFF
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= (FIFO_AW+1)'(FIFO_DEPTH))
      else $error("output queue over capacity");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |-> (occ_ff < (FIFO_AW+1)'(FIFO_DEPTH)))
      else $error("read data returned into a full queue");

   a_half_stall: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == KIND_WRITE) && req_tdata[96]
       && (req_tdata[71:64] < HALF_LIMIT)) |=> !req_tready)
      else $error("dimmed copy write not given its own cycle");
`endif

endmodule

[tb/tb.sv]
// Self-checking bench for planar_to_chunky_palette_lookup: directed and random items,
// predicted pixels in a scoreboard class, random idling and backpressure on both sides.
// Depends on p2c_pkg and the RTL under hdl/.

module tb
   import p2c_pkg::*;
();

   localparam logic [1:0] KIND_UNUSED   = 2'd3;
   localparam int         STALL_LIMIT   = 5000;
   localparam int         SETTLE_CYCLES = 12;
   localparam int         PHASE_ITEMS   = 45;

   typedef struct {
      logic [31:0] pixel;
      logic        last;
   } pixel_type;

   class palette_scoreboard;
      logic [15:0] pal565 [PALETTE_ENTRIES];
      logic [23:0] pal888 [PALETTE_ENTRIES];
      logic [3:0]  plane_count;
      logic        pixel_format;
      pixel_type   pending [$];
      int          errors;

      function new();
         foreach (pal565[i]) begin
            pal565[i] = '0;
            pal888[i] = '0;
         end
         plane_count  = 4'd8;
         pixel_format = 1'b0;
         errors       = 0;
      endfunction

      function void write_csr(logic idx, logic [3:0] value);
         if (idx == CSR_PLANE_COUNT) begin
            plane_count = value;
         end else begin
            pixel_format = value[0];
         end
      endfunction

      function int two_thirds(int v);
         return (v * 2) / 3;
      endfunction

      function logic [31:0] colour_at(int idx);
         if (idx >= PALETTE_ENTRIES) return pixel_format ? {ALPHA, 24'h0} : 32'h0;
         return pixel_format ? {ALPHA, pal888[idx]} : {16'h0, pal565[idx]};
      endfunction

      function void store_colour(logic [7:0] idx, logic [7:0] r, logic [7:0] g,
                                 logic [7:0] b, logic half);
         int h;
         h = int'(HALF_BASE) + int'(idx);
         if (int'(idx) >= PALETTE_ENTRIES) return;
         pal565[idx] = {r[7:3], g[7:2], b[7:3]};
         pal888[idx] = {r, g, b};
         // dimmed copy only for the low 32 entries
         if (half && idx < HALF_LIMIT && h < PALETTE_ENTRIES) begin
            pal565[h] = {5'(two_thirds(r[7:3])), 6'(two_thirds(g[7:2])),
                         5'(two_thirds(b[7:3]))};
            pal888[h] = {8'(two_thirds(r)), 8'(two_thirds(g)), 8'(two_thirds(b))};
         end
      endfunction

      function void note_item(logic [1:0] kind, logic [103:0] data);
         logic [63:0] planes;
         logic [7:0]  idx;
         int          np;
         int          pix_idx;
         planes = data[63:0];
         idx    = data[71:64];
         case (kind)
            KIND_WRITE: begin
               store_colour(idx, data[79:72], data[87:80], data[95:88], data[96]);
            end
            KIND_PLANAR: begin
               np = (plane_count > MAX_PLANES) ? MAX_PLANES : int'(plane_count);
               for (int p = 0; p < PIXELS_PER_ITEM; p++) begin
                  pix_idx = 0;
                  for (int k = 0; k < np; k++)
                     if (planes[8 * k + 7 - p]) pix_idx |= 1 << k;
                  pending.push_back('{colour_at(pix_idx), p == PIXELS_PER_ITEM - 1});
               end
            end
            KIND_CHUNKY: begin
               pending.push_back('{colour_at(int'(idx)), 1'b1});
            end
            default: begin
            end
         endcase
      endfunction

      function void check_pixel(logic [31:0] pixel, logic last);
         pixel_type want;
         if (pending.size() == 0) begin
            errors++;
            $error("pixel: expected nothing, actual 0x%08h", pixel);
            return;
         end
         want = pending.pop_front();
         if (pixel !== want.pixel) begin
            errors++;
            $error("pixel: expected 0x%08h, actual 0x%08h", want.pixel, pixel);
         end
         if (last !== want.last) begin
            errors++;
            $error("last: expected %0b, actual %0b", want.last, last);
         end
      endfunction
   endclass

   logic         clock       = 1'b0;
   logic         reset       = 1'b1;
   logic         req_tvalid  = 1'b0;
   logic         req_tready;
   logic [103:0] req_tdata   = '0;  // plane_bytes, color_index, red, green, blue, make_half
   logic [1:0]   req_tuser   = '0;  // kind
   logic         rsp_tvalid;
   logic         rsp_tready  = 1'b0;
   logic [31:0]  rsp_tdata;         // pixel
   logic         rsp_tlast;
   logic         csr_we      = 1'b0;
   logic         csr_index   = 1'b0;
   logic [3:0]   csr_wdata   = '0;

   palette_scoreboard sb;
   bit req_idle_en  = 1'b1;
   bit rsp_idle_en  = 1'b1;
   int rsp_hold     = 0;
   int quiet_cycles = 0;

   planar_to_chunky_palette_lookup u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_item(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_pixel(rsp_tdata, rsp_tlast);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == STALL_LIMIT) begin
         $display("planar_to_chunky_palette_lookup regression: fail");
         $finish;
      end
   end

   // receiver: random stalls, or a long hold when asked
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (rsp_hold) @(posedge clock);
            rsp_hold = 0;
         end else begin
            rsp_tready <= !(rsp_idle_en && $urandom_range(99) < 12);
         end
      end
   end

   function automatic logic [103:0] pack_req(logic [63:0] planes, logic [7:0] idx,
                                             logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                             logic half);
      return {7'b0, half, b, g, r, idx, planes};
   endfunction

   task automatic send_item(input logic [1:0] kind, input logic [103:0] data);
      if (req_idle_en && $urandom_range(99) < 12) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain_pixels();
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_mode(input logic [3:0] planes, input logic fmt);
      csr_we    <= 1'b1;
      csr_index <= CSR_PLANE_COUNT;
      csr_wdata <= planes;
      @(posedge clock);
      csr_index <= CSR_PIXEL_FORMAT;
      csr_wdata <= {3'b0, fmt};
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.write_csr(CSR_PLANE_COUNT, planes);
      sb.write_csr(CSR_PIXEL_FORMAT, {3'b0, fmt});
   endtask

   task automatic send_random(inout int counted);
      int           pick;
      logic [1:0]   kind;
      logic [103:0] data;
      pick = $urandom_range(99);
      kind = (pick < 30) ? KIND_WRITE : (pick < 70) ? KIND_PLANAR :
             (pick < 93) ? KIND_CHUNKY : KIND_UNUSED;
      data = pack_req({$urandom, $urandom}, 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom), 1'($urandom));
      if (kind == KIND_WRITE && $urandom_range(1) == 1) data[71:64] = 8'($urandom_range(31));
      if (kind == KIND_CHUNKY && $urandom_range(3) == 0)
         data[71:64] = 8'(int'(HALF_BASE) + $urandom_range(31));
      send_item(kind, data);
      if (kind != KIND_UNUSED) counted++;
   endtask

   initial begin
      int   counted;
      int   phase_planes [7];
      logic phase_fmt [7];
      sb = new();
      phase_planes = '{8, 1, 0, 15, 3, 5, 8};
      phase_fmt    = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // palette writes: dimmed copies at both ends of the low range, skipped copies; then reads and an unused kind
      send_item(KIND_WRITE, pack_req(64'h0, 8'd0, 8'hff, 8'hff, 8'hff, 1'b1));
      send_item(KIND_WRITE, pack_req(64'h0, 8'd31, 8'h80, 8'h7f, 8'h01, 1'b1));
      send_item(KIND_WRITE, pack_req(64'h0, 8'd32, 8'h12, 8'h34, 8'h56, 1'b1));
      send_item(KIND_WRITE, pack_req('1, 8'd255, 8'hab, 8'hcd, 8'hef, 1'b1));
      send_item(KIND_WRITE, pack_req(64'h0, 8'd1, 8'h07, 8'h03, 8'hf8, 1'b0));
      send_item(KIND_WRITE, pack_req(64'h0, 8'd128, 8'h5a, 8'ha5, 8'h3c, 1'b0));
      send_item(KIND_CHUNKY, pack_req(64'h0, 8'd0, 8'h0, 8'h0, 8'h0, 1'b0));
      send_item(KIND_CHUNKY, pack_req(64'h0, 8'd224, 8'h0, 8'h0, 8'h0, 1'b0));
      send_item(KIND_CHUNKY, pack_req(64'h0, 8'd31, 8'h0, 8'h0, 8'h0, 1'b0));
      send_item(KIND_CHUNKY, pack_req(64'h0, 8'd255, 8'h0, 8'h0, 8'h0, 1'b0));
      send_item(KIND_CHUNKY, pack_req(64'h0, 8'd32, 8'h0, 8'h0, 8'h0, 1'b0));
      send_item(KIND_CHUNKY, pack_req(64'h0, 8'd1, 8'h0, 8'h0, 8'h0, 1'b0));
      send_item(KIND_CHUNKY, pack_req(64'h0, 8'd200, 8'h0, 8'h0, 8'h0, 1'b0));
      send_item(KIND_PLANAR, pack_req(64'h0, 8'd0, 8'h0, 8'h0, 8'h0, 1'b0));
      send_item(KIND_PLANAR, pack_req('1, 8'd0, 8'h0, 8'h0, 8'h0, 1'b0));
      send_item(KIND_PLANAR, pack_req(64'h8040201008040201, 8'd0, 8'h0, 8'h0, 8'h0, 1'b0));
      send_item(KIND_PLANAR, pack_req(64'hff00ff00aa55aa55, 8'd0, 8'h0, 8'h0, 8'h0, 1'b0));
      send_item(KIND_UNUSED, pack_req({$urandom, $urandom}, 8'd5, 8'h11, 8'h22, 8'h33, 1'b1));
      drain_pixels();

      set_mode(4'd8, 1'b1);
      send_item(KIND_CHUNKY, pack_req(64'h0, 8'd224, 8'h0, 8'h0, 8'h0, 1'b0));
      send_item(KIND_CHUNKY, pack_req(64'h0, 8'd255, 8'h0, 8'h0, 8'h0, 1'b0));
      send_item(KIND_PLANAR, pack_req(64'h0123456789abcdef, 8'd0, 8'h0, 8'h0, 8'h0, 1'b0));
      drain_pixels();
      set_mode(4'd0, 1'b0);
      send_item(KIND_PLANAR, pack_req('1, 8'd0, 8'h0, 8'h0, 8'h0, 1'b0));
      drain_pixels();
      set_mode(4'd15, 1'b1);
      send_item(KIND_PLANAR, pack_req({$urandom, $urandom}, 8'd0, 8'h0, 8'h0, 8'h0, 1'b0));
      drain_pixels();
      set_mode(4'd1, 1'b0);
      send_item(KIND_PLANAR, pack_req('1, 8'd0, 8'h0, 8'h0, 8'h0, 1'b0));
      drain_pixels();

      for (int ph = 0; ph < 7; ph++) begin
         set_mode(4'(phase_planes[ph]), phase_fmt[ph]);
         // long receiver hold while the sender keeps going
         if (ph == 1) rsp_hold = 80;
         req_idle_en = (ph != 3);
         rsp_idle_en = (ph != 3);
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            send_random(counted);
            if (ph == 5 && counted == PHASE_ITEMS / 2) drain_pixels();
         end
         drain_pixels();
      end

      repeat (16) @(posedge clock);
      if (sb.errors == 0) begin
         $display("planar_to_chunky_palette_lookup regression: pass");
      end else begin
         $display("planar_to_chunky_palette_lookup regression: fail");
      end
      $finish;
   end

endmodule
